/* design/bsop_pkg.sv */
package bsop_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CAP_W    = 5;
    localparam int unsigned COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_OPUSH   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REVERSE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

/* design/bsop_ram.sv */
module bsop_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic [bsop_pkg::DATA_W-1:0]      wr_data,
    input  logic [AW-1:0]                    rd_addr,
    output logic [bsop_pkg::DATA_W-1:0]      rd_data
);

    logic [bsop_pkg::DATA_W-1:0] mem [DEPTH];
    logic [bsop_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/bounded_stack_ordered_push.sv */
// Channel   Direction  Ports                                          Request
// s_        in         s_command, s_push_value                        one command
// m_        out        m_pop_value, m_status, m_entry_count,          one result
//                      m_is_empty, m_is_full
// cfg_      in         cfg_data                                       capacity limit write
//
// Push and refused commands go from idle straight to the result. Pop waits on a
// registered read of the single-write, single-read RAM. Ordered push reads and
// compares entries from the top down, moving each one not below the value up a
// slot, then writes the value. Reverse swaps pairs inward: two reads, two writes.
// Synchronous active-low reset empties the stack and sets the limit to 16.
// A result waiting on m_ready holds the sequencer in its final state.
module bounded_stack_ordered_push #(
    parameter int unsigned MAX_DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bsop_pkg::CMD_W-1:0]            s_command,
    input  logic signed [bsop_pkg::DATA_W-1:0]    s_push_value,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bsop_pkg::DATA_W-1:0]    m_pop_value,
    output logic [bsop_pkg::STATUS_W-1:0]         m_status,
    output logic [bsop_pkg::COUNT_W-1:0]          m_entry_count,
    output logic                                  m_is_empty,
    output logic                                  m_is_full,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bsop_pkg::CAP_W-1:0]            cfg_data
);

    localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned CW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned LW = (CW > bsop_pkg::CAP_W) ? CW : bsop_pkg::CAP_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(MAX_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_WAIT,
        ST_OP_READ,
        ST_OP_CMP,
        ST_RV_RD_LO,
        ST_RV_RD_HI,
        ST_RV_WR_LO,
        ST_RV_WR_HI,
        ST_DONE
    } state_t;

    state_t                                state_reg, state_next;
    logic [CW-1:0]                         count_reg, count_next;
    logic [bsop_pkg::CAP_W-1:0]            cap_reg;
    logic signed [bsop_pkg::DATA_W-1:0]    val_reg, val_next;
    logic [bsop_pkg::DATA_W-1:0]           tmp_reg, tmp_next;
    logic [AW-1:0]                         pos_reg, pos_next;
    logic [AW-1:0]                         lo_reg, lo_next;
    logic [AW-1:0]                         hi_reg, hi_next;
    logic [bsop_pkg::DATA_W-1:0]           res_pop_reg, res_pop_next;
    logic [bsop_pkg::STATUS_W-1:0]         res_status_reg, res_status_next;

    logic                                  m_valid_reg, m_valid_next;
    logic [bsop_pkg::DATA_W-1:0]           m_pop_value_reg, m_pop_value_next;
    logic [bsop_pkg::STATUS_W-1:0]         m_status_reg, m_status_next;
    logic [bsop_pkg::COUNT_W-1:0]          m_entry_count_reg, m_entry_count_next;
    logic                                  m_is_empty_reg, m_is_empty_next;
    logic                                  m_is_full_reg, m_is_full_next;

    logic                                  wr_en;
    logic [AW-1:0]                         wr_addr;
    logic [bsop_pkg::DATA_W-1:0]           wr_data;
    logic [AW-1:0]                         rd_addr;
    logic [bsop_pkg::DATA_W-1:0]           rd_data;

    logic [LW-1:0]                         cap_l, lim_l, count_l;
    logic                                  at_limit;
    logic                                  s_accept;
    logic                                  out_free;

    bsop_ram #(
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cap_l    = LW'(cap_reg);
    assign lim_l    = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
    assign count_l  = LW'(count_reg);
    assign at_limit = (count_l >= lim_l);

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next         = state_reg;
        count_next         = count_reg;
        val_next           = val_reg;
        tmp_next           = tmp_reg;
        pos_next           = pos_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        res_pop_next       = res_pop_reg;
        res_status_next    = res_status_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_pop_value_next   = m_pop_value_reg;
        m_status_next      = m_status_reg;
        m_entry_count_next = m_entry_count_reg;
        m_is_empty_next    = m_is_empty_reg;
        m_is_full_next     = m_is_full_reg;
        wr_en              = 1'b0;
        wr_addr            = count_reg[AW-1:0];
        wr_data            = s_push_value;
        rd_addr            = count_reg[AW-1:0] - 1'b1;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    res_pop_next    = '0;
                    res_status_next = bsop_pkg::STATUS_OK;
                    state_next      = ST_DONE;
                    case (s_command)
                        bsop_pkg::CMD_PUSH: begin
                            if (at_limit) begin
                                res_status_next = bsop_pkg::STATUS_OVERFLOW;
                            end else begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bsop_pkg::CMD_POP: begin
                            if (count_reg == '0) begin
                                res_status_next = bsop_pkg::STATUS_UNDERFLOW;
                            end else begin
                                state_next = ST_POP_WAIT;
                            end
                        end
                        bsop_pkg::CMD_OPUSH: begin
                            if (at_limit) begin
                                res_status_next = bsop_pkg::STATUS_OVERFLOW;
                            end else begin
                                val_next   = s_push_value;
                                pos_next   = count_reg[AW-1:0];
                                state_next = ST_OP_READ;
                            end
                        end
                        default: begin
                            if (count_reg > CW'(1)) begin
                                lo_next    = '0;
                                hi_next    = count_reg[AW-1:0] - 1'b1;
                                state_next = ST_RV_RD_LO;
                            end
                        end
                    endcase
                end
            end
            ST_POP_WAIT: begin
                res_pop_next = rd_data;
                count_next   = count_reg - 1'b1;
                state_next   = ST_DONE;
            end
            ST_OP_READ: begin
                rd_addr = pos_reg - 1'b1;
                if (pos_reg == '0) begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_OP_CMP;
                end
            end
            ST_OP_CMP: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if ($signed(rd_data) >= val_reg) begin
                    wr_data    = rd_data;
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_OP_READ;
                end else begin
                    wr_data    = val_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_RV_RD_LO: begin
                rd_addr    = lo_reg;
                state_next = ST_RV_RD_HI;
            end
            ST_RV_RD_HI: begin
                tmp_next   = rd_data;
                rd_addr    = hi_reg;
                state_next = ST_RV_WR_LO;
            end
            ST_RV_WR_LO: begin
                wr_en      = 1'b1;
                wr_addr    = lo_reg;
                wr_data    = rd_data;
                state_next = ST_RV_WR_HI;
            end
            ST_RV_WR_HI: begin
                wr_en   = 1'b1;
                wr_addr = hi_reg;
                wr_data = tmp_reg;
                lo_next = lo_reg + 1'b1;
                hi_next = hi_reg - 1'b1;
                if ((lo_reg + 1'b1) < (hi_reg - 1'b1)) begin
                    state_next = ST_RV_RD_LO;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_pop_value_next   = res_pop_reg;
                    m_status_next      = res_status_reg;
                    m_entry_count_next = count_l[bsop_pkg::COUNT_W-1:0];
                    m_is_empty_next    = (count_reg == '0);
                    m_is_full_next     = at_limit;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cap_reg     <= bsop_pkg::CAP_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
        val_reg           <= val_next;
        tmp_reg           <= tmp_next;
        pos_reg           <= pos_next;
        lo_reg            <= lo_next;
        hi_reg            <= hi_next;
        res_pop_reg       <= res_pop_next;
        res_status_reg    <= res_status_next;
        m_pop_value_reg   <= m_pop_value_next;
        m_status_reg      <= m_status_next;
        m_entry_count_reg <= m_entry_count_next;
        m_is_empty_reg    <= m_is_empty_next;
        m_is_full_reg     <= m_is_full_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_pop_value   = m_pop_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_is_empty    = m_is_empty_reg;
    assign m_is_full     = m_is_full_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_l <= DEPTH_L)
        else $error("stack count above depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("sequencer did not leave idle after a request");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == bsop_pkg::STATUS_OVERFLOW) |-> m_is_full)
        else $error("overflow reported without full flag");

    a_underflow_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == bsop_pkg::STATUS_UNDERFLOW)
            |-> (m_is_empty && m_pop_value == '0))
        else $error("underflow result inconsistent");

endmodule
